[sv/crc16_chunk_zero_fill_core_defines.svh]
// assertion macros shared by the chunked crc block
`ifndef CRC16_CHUNK_ZERO_FILL_CORE_DEFINES_SVH
`define CRC16_CHUNK_ZERO_FILL_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CZ_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define CZ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/crc16cz_pkg.sv]
`timescale 1ns / 1ps

package crc16cz_pkg;

	// field widths
	localparam int CRC_W  = 16;
	localparam int BYTE_W = 8;
	localparam int FILL_W = 8;

	// default chunk length in bytes
	localparam int CHUNK_BYTES_DEF = 256;

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam logic [CFG_ADDR_W-1:0] REG_POLYNOMIAL  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_START_VALUE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_FINAL_XOR   = 2'd2;

	// register reset values
	localparam logic [CRC_W-1:0] POLY_RST  = 16'h1021;
	localparam logic [CRC_W-1:0] START_RST = 16'hFFFF;
	localparam logic [CRC_W-1:0] XOR_RST   = 16'hFFFF;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FILL,
		ST_EMIT
	} state_t;

	// controls for the bit-serial crc unit
	typedef struct packed {
		logic load;       // take a new data byte
		logic use_start;  // first byte of a chunk: seed from start value
		logic shift;      // advance one bit
	} crc_ctl_t;

endpackage

[sv/crc16cz_crc_unit.sv]
`timescale 1ns / 1ps

module crc16cz_crc_unit (
	input  logic                               clk,
	input  crc16cz_pkg::crc_ctl_t              ctl,
	input  logic [crc16cz_pkg::BYTE_W-1:0]     data_byte,
	input  logic [crc16cz_pkg::CRC_W-1:0]      polynomial,
	input  logic [crc16cz_pkg::CRC_W-1:0]      start_value,
	output logic [crc16cz_pkg::CRC_W-1:0]      crc
);

	logic [crc16cz_pkg::CRC_W-1:0]  crc_q;
	logic [crc16cz_pkg::BYTE_W-1:0] dat_q;
	logic                           fb;
	logic [crc16cz_pkg::CRC_W-1:0]  crc_shifted;
	logic [crc16cz_pkg::CRC_W-1:0]  crc_d;

	// one msb-first step; data bits run out as zeros, which serves the fill
	assign fb          = crc_q[crc16cz_pkg::CRC_W-1] ^ dat_q[crc16cz_pkg::BYTE_W-1];
	assign crc_shifted = {crc_q[crc16cz_pkg::CRC_W-2:0], 1'b0} ^
	                     (fb ? polynomial : '0);
	assign crc_d       = ctl.shift ? crc_shifted : crc_q;

	// crc and data shift registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			crc_q <= ctl.use_start ? start_value : crc_d;
			dat_q <= data_byte;
		end else if (ctl.shift) begin
			crc_q <= crc_shifted;
			dat_q <= {dat_q[crc16cz_pkg::BYTE_W-2:0], 1'b0};
		end
	end

	assign crc = crc_q;

endmodule

[sv/crc16_chunk_zero_fill_core.sv]
`timescale 1ns / 1ps

// Chunked CRC-16 with zero fill. Bytes enter on the in channel with a last
// flag; each is shifted MSB first through a bit-serial CRC register, one bit
// per clock, and the next byte of a chunk can be taken in the cycle that
// shifts the last bit of the byte before. A chunk closes after CHUNK_BYTES
// bytes or at a byte marked last; a short chunk then clocks zero bytes
// through the same register, and in the emit state the result (CRC XOR
// final_xor, fill count saturated at 255) moves into the output register.
// The block then returns to idle, where it can take the next item. The next
// item can enter while the result waits to be read; a chunk that closes
// while an earlier result is still unread holds in the emit state, with
// the input stalled, until that result is taken.
// Configuration writes (polynomial, start value, final XOR) apply whenever
// the block is idle; the start value is sampled at each chunk's first byte.
module crc16_chunk_zero_fill_core #(
	parameter int CHUNK_BYTES = crc16cz_pkg::CHUNK_BYTES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration
	input  logic                                  cfg_wr_en,
	input  logic [crc16cz_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [crc16cz_pkg::CRC_W-1:0]         cfg_wdata,
	// input items
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [crc16cz_pkg::BYTE_W-1:0]        data_byte,
	input  logic                                  last,
	// result items
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [crc16cz_pkg::CRC_W-1:0]         crc_value,
	output logic [crc16cz_pkg::FILL_W-1:0]        fill_count
);

	localparam int CW = $clog2(CHUNK_BYTES + 1);
	localparam logic [CW-1:0] CHUNK_LEN = CW'(CHUNK_BYTES);

	crc16cz_pkg::state_t   state_q, state_d;
	crc16cz_pkg::crc_ctl_t crc_ctl;

	logic [crc16cz_pkg::CRC_W-1:0]  poly_q, start_q, fxor_q;
	logic [crc16cz_pkg::CRC_W-1:0]  crc;
	logic [CW-1:0]                  cnt_q;
	logic [2:0]                     bit_q;
	logic                           last_q;
	logic [crc16cz_pkg::FILL_W-1:0] fill_q;
	logic                           out_valid_q;
	logic [crc16cz_pkg::CRC_W-1:0]  crc_value_q;
	logic [crc16cz_pkg::FILL_W-1:0] fill_count_q;

	logic          accept, byte_end, full, closing;
	logic          cnt_inc, cnt_clr, fill_ld, out_ld;
	logic [CW-1:0] diff;
	logic [15:0]   diff_ext;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poly_q  <= crc16cz_pkg::POLY_RST;
			start_q <= crc16cz_pkg::START_RST;
			fxor_q  <= crc16cz_pkg::XOR_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				crc16cz_pkg::REG_POLYNOMIAL:  poly_q  <= cfg_wdata;
				crc16cz_pkg::REG_START_VALUE: start_q <= cfg_wdata;
				crc16cz_pkg::REG_FINAL_XOR:   fxor_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// chunk status
	assign byte_end = (bit_q == 3'd7);
	assign full     = (cnt_q == CHUNK_LEN);
	assign closing  = full || last_q;
	assign accept   = in_valid && in_ready;

	// zero bytes still owed, widened to 16 bits for the saturation below
	assign diff     = CHUNK_LEN - cnt_q;
	assign diff_ext = 16'(diff);

	// next state and controls
	always_comb begin
		state_d           = state_q;
		in_ready          = 1'b0;
		crc_ctl.load      = 1'b0;
		crc_ctl.use_start = 1'b0;
		crc_ctl.shift     = 1'b0;
		cnt_inc           = 1'b0;
		cnt_clr           = 1'b0;
		fill_ld           = 1'b0;
		out_ld            = 1'b0;
		case (state_q)
			crc16cz_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = crc16cz_pkg::ST_SHIFT;
				end
			end
			crc16cz_pkg::ST_SHIFT: begin
				crc_ctl.shift = 1'b1;
				if (byte_end) begin
					if (!closing) begin
						in_ready = 1'b1;
						state_d  = in_valid ? crc16cz_pkg::ST_SHIFT : crc16cz_pkg::ST_IDLE;
					end else begin
						fill_ld = 1'b1;
						state_d = full ? crc16cz_pkg::ST_EMIT : crc16cz_pkg::ST_FILL;
					end
				end
			end
			crc16cz_pkg::ST_FILL: begin
				crc_ctl.shift = 1'b1;
				if (byte_end) begin
					cnt_inc = 1'b1;
					if (cnt_q + 1'b1 == CHUNK_LEN) begin
						state_d = crc16cz_pkg::ST_EMIT;
					end
				end
			end
			crc16cz_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					out_ld  = 1'b1;
					cnt_clr = 1'b1;
					state_d = crc16cz_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = crc16cz_pkg::ST_IDLE;
			end
		endcase
		if (accept) begin
			crc_ctl.load      = 1'b1;
			crc_ctl.use_start = (cnt_q == '0);
			cnt_inc           = 1'b1;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= crc16cz_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// bit and byte counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			cnt_q <= '0;
		end else begin
			if (crc_ctl.shift) begin
				bit_q <= bit_q + 3'd1;
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// last flag and fill length of the current chunk
	always_ff @(posedge clk) begin
		if (accept) begin
			last_q <= last;
		end
		if (fill_ld) begin
			fill_q <= (diff_ext > 16'd255) ? 8'hFF : diff_ext[7:0];
		end
	end

	// bit-serial crc
	crc16cz_crc_unit u_crc (
		.clk         (clk),
		.ctl         (crc_ctl),
		.data_byte   (data_byte),
		.polynomial  (poly_q),
		.start_value (start_q),
		.crc         (crc)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			crc_value_q  <= crc ^ fxor_q;
			fill_count_q <= fill_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign crc_value  = crc_value_q;
	assign fill_count = fill_count_q;

	// checks
	`include "crc16_chunk_zero_fill_core_defines.svh"

	`CZ_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_q <= CHUNK_LEN, "byte count past chunk length")
	`CZ_ASSERT_IMPLY(a_fill_short, state_q == crc16cz_pkg::ST_FILL, cnt_q < CHUNK_LEN, "fill on a full chunk")
	`CZ_ASSERT_IMPLY(a_emit_src, $rose(out_valid_q), $past(state_q == crc16cz_pkg::ST_EMIT), "result loaded outside emit")
	`CZ_ASSERT_NEXT(a_emit_clr, out_ld, cnt_q == '0, "chunk not restarted after result")

endmodule

[sim/crc16_chunk_zero_fill_core_tb.sv]
`timescale 1ns / 1ps

// expected result of one closed chunk
typedef struct packed {
	logic [15:0] crc;
	logic [7:0]  fill;
} chunk_result_t;

// running crc of the current chunk and the results still owed by the block
class chunk_crc_tracker;
	logic [15:0] poly;
	logic [15:0] seed;
	logic [15:0] out_mask;
	logic [15:0] crc_run;
	int unsigned bytes_run;
	chunk_result_t chunk_results_due[$];
	int errors;
	int results_seen;

	function new();
		poly = crc16cz_pkg::POLY_RST;
		seed = crc16cz_pkg::START_RST;
		out_mask = crc16cz_pkg::XOR_RST;
		crc_run = seed;
		bytes_run = 0;
		errors = 0;
		results_seen = 0;
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function void set_reg(logic [crc16cz_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
		case (idx)
			crc16cz_pkg::REG_POLYNOMIAL: poly = val;
			crc16cz_pkg::REG_START_VALUE: seed = val;
			crc16cz_pkg::REG_FINAL_XOR: out_mask = val;
			default: ;
		endcase
	endfunction

	// one byte through the crc, msb first
	function logic [15:0] crc_shift_byte(logic [15:0] c, logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int i = 0; i < 8; i++)
			r = r[15] ? ((r << 1) ^ poly) : (r << 1);
		return r;
	endfunction

	// accepted input item: advance the chunk, close it with zero fill if due
	function void take_byte(logic [7:0] b, logic l);
		chunk_result_t res;
		int unsigned fill;
		if (bytes_run == 0)
			crc_run = seed;
		crc_run = crc_shift_byte(crc_run, b);
		bytes_run++;
		if (bytes_run < crc16cz_pkg::CHUNK_BYTES_DEF && !l)
			return;
		fill = crc16cz_pkg::CHUNK_BYTES_DEF - bytes_run;
		while (bytes_run < crc16cz_pkg::CHUNK_BYTES_DEF) begin
			crc_run = crc_shift_byte(crc_run, 8'h00);
			bytes_run++;
		end
		res.crc = crc_run ^ out_mask;
		res.fill = (fill > 255) ? 8'd255 : fill[7:0];
		chunk_results_due.push_back(res);
		crc_run = seed;
		bytes_run = 0;
	endfunction

	// accepted result item against the oldest expectation
	task match_result(logic [15:0] crc, logic [7:0] fill);
		chunk_result_t want;
		results_seen++;
		if (chunk_results_due.size() == 0) begin
			report($sformatf("result crc %h fill %0d with nothing expected", crc, fill));
			return;
		end
		want = chunk_results_due.pop_front();
		if (crc !== want.crc)
			report($sformatf("crc_value %h, expected %h", crc, want.crc));
		if (fill !== want.fill)
			report($sformatf("fill_count %0d, expected %0d", fill, want.fill));
	endtask

	function int pending();
		return chunk_results_due.size();
	endfunction
endclass

module crc16_chunk_zero_fill_core_tb;

	localparam int HOLD_LEN = 5000;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 2100;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [crc16cz_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [crc16cz_pkg::CRC_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [crc16cz_pkg::BYTE_W-1:0] data_byte = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [crc16cz_pkg::CRC_W-1:0] crc_value;
	logic [crc16cz_pkg::FILL_W-1:0] fill_count;

	chunk_crc_tracker sb;
	int send_idle = 0;
	int recv_idle = 0;
	int items_sent = 0;
	logic hold_req = 1'b0;
	int hold_cnt = 0;
	int stall_cnt = 0;

	crc16_chunk_zero_fill_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.crc_value(crc_value),
		.fill_count(fill_count)
	);

	always #2 clk = ~clk;

	// result side: check accepted results, random stalls, one long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_result(crc_value, fill_count);
		if (hold_req && hold_cnt < HOLD_LEN) begin
			hold_cnt <= hold_cnt + 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// offer one item, idling first at the current rate, hold until taken
	task send_item(logic [7:0] b, logic l);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last <= l;
		do
			@(posedge clk);
		while (!in_ready);
		sb.take_byte(b, l);
		items_sent++;
	endtask

	function logic [7:0] pick_byte();
		int r;
		r = $urandom_range(15);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(255));
	endfunction

	task send_chunk(int len, bit close);
		for (int i = 0; i < len; i++)
			send_item(pick_byte(), close && (i == len - 1));
	endtask

	// stop offering, wait for every owed result, then let the block finish
	task settle(int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task cfg_write(logic [crc16cz_pkg::CFG_ADDR_W-1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task set_regs(logic [15:0] p, logic [15:0] s, logic [15:0] x);
		cfg_write(crc16cz_pkg::REG_POLYNOMIAL, p);
		cfg_write(crc16cz_pkg::REG_START_VALUE, s);
		cfg_write(crc16cz_pkg::REG_FINAL_XOR, x);
	endtask

	// random chunks, mostly short, until the item and result counts are met
	task run_phase(int budget, int want_results);
		int first_item;
		int first_result;
		int r;
		int len;
		first_item = items_sent;
		first_result = sb.results_seen;
		while (items_sent - first_item < budget || sb.results_seen - first_result < want_results) begin
			r = $urandom_range(99);
			if (r < 80)
				len = $urandom_range(1, 6);
			else if (r < 95)
				len = $urandom_range(7, 60);
			else
				len = $urandom_range(61, 255);
			send_chunk(len, 1'b1);
		end
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed chunks at reset settings
		send_idle <= 37;
		recv_idle <= 66;
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(8'h80, 1'b0);
		send_item(8'h01, 1'b1);
		send_item(8'hAA, 1'b0);
		send_item(8'h55, 1'b0);
		send_item(8'h0F, 1'b0);
		send_item(8'hF0, 1'b1);

		// start value changed inside an open chunk applies from the next chunk
		send_item(8'h12, 1'b0);
		send_item(8'h34, 1'b0);
		settle(24);
		cfg_write(crc16cz_pkg::REG_START_VALUE, 16'h0000);
		send_item(8'h56, 1'b1);
		send_item(8'h78, 1'b1);

		// polynomial and final mask changed inside an open chunk
		send_item(8'h9C, 1'b0);
		settle(24);
		cfg_write(crc16cz_pkg::REG_POLYNOMIAL, 16'h8005);
		cfg_write(crc16cz_pkg::REG_FINAL_XOR, 16'h0000);
		send_item(8'h3E, 1'b1);
		settle(24);

		// phase one: all-ones polynomial, full chunk closed by the count
		set_regs(16'hFFFF, 16'h0000, 16'hFFFF);
		send_chunk(256, 1'b0);
		run_phase(40, 6);
		settle(24);

		// phase two: zero polynomial, rates swapped
		send_idle <= 66;
		recv_idle <= 37;
		set_regs(16'h0000, 16'hFFFF, 16'h0000);
		run_phase(80, 6);
		settle(24);

		// phase three: random settings, no idling, long receiver hold-off
		send_idle <= 0;
		recv_idle <= 0;
		set_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)));
		hold_req <= 1'b1;
		run_phase(30, 3);
		send_chunk(256, 1'b1);
		run_phase(40, 3);
		settle(DRAIN_CYCLES);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/crc16cz_pkg.sv
sv/crc16cz_crc_unit.sv
sv/crc16_chunk_zero_fill_core.sv
sim/crc16_chunk_zero_fill_core_tb.sv
